### sv/sks_pkg.sv
`default_nettype none
package sks_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// Field widths fixed by the interface.
	localparam int ENTRY_INDEX_W = 12;
	localparam int KEY_WORD_W    = 56;
	localparam int KEY_WORDS     = 4;
	localparam int KEY_W         = KEY_WORD_W * KEY_WORDS;
	localparam int OFFSET_W      = 32;
	localparam int COUNT_W       = 16;
	localparam int ADDR_W        = OFFSET_W + 1;

	// Configuration registers.
	localparam int ENTRY_CNT_W = 13;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PLAY_AREA_BASE = 1'b1;

	// Request kinds.
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef logic [KEY_W-1:0] key_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;      // write the incoming entry into the table
		logic start;     // capture the query key and open the search window
		logic rd;        // read the entry at the window midpoint
		logic step;      // compare and narrow the window
		logic out_load;  // move the finished result into the output register
	} sks_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic lo_lt_hi;  // search window not empty
		logic key_eq;    // query equals the entry just read
	} sks_sts_t;

endpackage
`default_nettype wire

### sv/sks_if.sv
`default_nettype none
interface sks_req_if;
	import sks_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [ENTRY_INDEX_W-1:0] entry_index;
	logic [KEY_WORD_W-1:0]    key_word_0;
	logic [KEY_WORD_W-1:0]    key_word_1;
	logic [KEY_WORD_W-1:0]    key_word_2;
	logic [KEY_WORD_W-1:0]    key_word_3;
	logic [OFFSET_W-1:0]      payload_offset;
	logic [COUNT_W-1:0]       payload_count;

	modport source (
		output valid, req_type, entry_index, key_word_0, key_word_1, key_word_2,
			key_word_3, payload_offset, payload_count,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_index, key_word_0, key_word_1, key_word_2,
			key_word_3, payload_offset, payload_count,
		output ready
	);
endinterface

interface sks_rsp_if;
	import sks_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     found;
	logic [COUNT_W-1:0]       play_count;
	logic [ADDR_W-1:0]        play_address;
	logic [ENTRY_INDEX_W-1:0] matched_index;

	modport source (
		output valid, found, play_count, play_address, matched_index,
		input  ready
	);
	modport sink (
		input  valid, found, play_count, play_address, matched_index,
		output ready
	);
endinterface
`default_nettype wire

### sv/sks_ctrl.sv
`default_nettype none
module sks_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_req_type,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire sks_pkg::sks_sts_t sts,
	output sks_pkg::sks_cmd_t      cmd
);
	import sks_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid && (in_req_type == REQ_LOAD);
		cmd.start    = (state_q == S_IDLE) && in_valid && (in_req_type == REQ_SEARCH);
		cmd.rd       = (state_q == S_PROBE) && sts.lo_lt_hi;
		cmd.step     = (state_q == S_CMP);
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= sts.lo_lt_hi ? S_CMP : S_DONE;
				end
				S_CMP: begin
					state_q <= sts.key_eq ? S_DONE : S_PROBE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A match ends the halving loop at once.
	a_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && sts.key_eq) |=> (state_q == S_DONE))
		else $error("search continued after a key match");

	// A finished result waits while the output register is still occupied.
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("result overwrote a pending transaction");

	// A new result only appears out of the finishing state.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the finishing state");

endmodule
`default_nettype wire

### sv/sks_dp.sv
`default_nettype none
module sks_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sks_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [sks_pkg::CFG_DATA_W-1:0]  cfg_data,
	sks_req_if.sink                            req,
	sks_rsp_if.source                          rsp,
	input  wire sks_pkg::sks_cmd_t             cmd,
	output sks_pkg::sks_sts_t                  sts
);
	import sks_pkg::*;

	// Configuration registers.
	logic [ENTRY_CNT_W-1:0] entry_count_q;
	logic [OFFSET_W-1:0]    play_area_base_q;

	// Table memories.
	key_t                        key_mem [TABLE_DEPTH];
	logic [COUNT_W+OFFSET_W-1:0] pay_mem [TABLE_DEPTH];

	// Search state.
	key_t                        query_q;
	logic [ENTRY_CNT_W-1:0]      lo_q;
	logic [ENTRY_CNT_W-1:0]      hi_q;
	logic [IDX_W-1:0]            mid_q;
	key_t                        rd_key_q;
	logic [COUNT_W+OFFSET_W-1:0] rd_pay_q;

	// Result of the current search and the output register.
	logic                     res_found_q;
	logic [COUNT_W-1:0]       res_count_q;
	logic [ADDR_W-1:0]        res_addr_q;
	logic [ENTRY_INDEX_W-1:0] res_index_q;
	logic                     out_found_q;
	logic [COUNT_W-1:0]       out_count_q;
	logic [ADDR_W-1:0]        out_addr_q;
	logic [ENTRY_INDEX_W-1:0] out_index_q;

	logic [ENTRY_CNT_W-1:0] n_search;
	logic [ENTRY_CNT_W:0]   mid_sum;
	logic [IDX_W-1:0]       mid;
	logic                   key_lt;
	logic                   load_ok;
	key_t                   in_key;

	assign in_key   = {req.key_word_0, req.key_word_1, req.key_word_2, req.key_word_3};
	assign n_search = (entry_count_q > ENTRY_CNT_W'(TABLE_DEPTH)) ?
		ENTRY_CNT_W'(TABLE_DEPTH) : entry_count_q;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[IDX_W:1];
	assign key_lt   = (query_q < rd_key_q);
	assign load_ok  = ({1'b0, req.entry_index} < (ENTRY_INDEX_W + 1)'(TABLE_DEPTH));

	assign sts.lo_lt_hi = (lo_q < hi_q);
	assign sts.key_eq   = (query_q == rd_key_q);

	assign rsp.found         = out_found_q;
	assign rsp.play_count    = out_count_q;
	assign rsp.play_address  = out_addr_q;
	assign rsp.matched_index = out_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q    <= '0;
			play_area_base_q <= '0;
			lo_q             <= '0;
			hi_q             <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENTRY_COUNT:    entry_count_q    <= cfg_data[ENTRY_CNT_W-1:0];
					CFG_PLAY_AREA_BASE: play_area_base_q <= cfg_data[OFFSET_W-1:0];
					default:            ;
				endcase
			end
			if (cmd.start) begin
				lo_q <= '0;
				hi_q <= n_search;
			end else if (cmd.step && !sts.key_eq) begin
				if (key_lt) begin
					hi_q <= ENTRY_CNT_W'(mid_q);
				end else begin
					lo_q <= ENTRY_CNT_W'(mid_q) + ENTRY_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			key_mem[req.entry_index[IDX_W-1:0]] <= in_key;
			pay_mem[req.entry_index[IDX_W-1:0]] <= {req.payload_count, req.payload_offset};
		end
		if (cmd.rd) begin
			rd_key_q <= key_mem[mid];
			rd_pay_q <= pay_mem[mid];
			mid_q    <= mid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			query_q     <= in_key;
			res_found_q <= 1'b0;
			res_count_q <= '0;
			res_addr_q  <= '0;
			res_index_q <= '0;
		end else if (cmd.step && sts.key_eq) begin
			res_found_q <= 1'b1;
			res_count_q <= rd_pay_q[COUNT_W+OFFSET_W-1:OFFSET_W];
			res_addr_q  <= {1'b0, play_area_base_q} + {1'b0, rd_pay_q[OFFSET_W-1:0]};
			res_index_q <= ENTRY_INDEX_W'(mid_q);
		end
		if (cmd.out_load) begin
			out_found_q <= res_found_q;
			out_count_q <= res_count_q;
			out_addr_q  <= res_addr_q;
			out_index_q <= res_index_q;
		end
	end

	// Halving never inverts the window.
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("search window inverted");

	// The window never reaches past the table.
	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hi_q <= ENTRY_CNT_W'(TABLE_DEPTH))
		else $error("search window beyond table depth");

	// Every compare works on data read in the cycle before.
	a_step_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> $past(cmd.rd))
		else $error("compare without a preceding table read");

endmodule
`default_nettype wire

### sv/sorted_key_table_search.sv
`default_nettype none
// Channel   Role     Transaction payload
// req       sink     req_type, entry_index, key_word_0..3, payload_offset, payload_count
// rsp       source   found, play_count, play_address, matched_index
// cfg       write    cfg_we, cfg_index (0 entry_count, 1 play_area_base), cfg_data
//
// A load is written into the table at the edge that accepts it and returns no result.
// A search runs halving steps, each a table read and then a 224-bit compare, at most
// 13 steps for 4096 entries, after the accept; after a miss a probe finds the window empty,
// then the finishing state passes the result on; no new request is taken until it ends.
// Reset clears the configuration and the control state; the table is not cleared.
// A waiting result blocks no request; a search stalls at its end while the output is full.
module sorted_key_table_search (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sks_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [sks_pkg::CFG_DATA_W-1:0]  cfg_data,
	sks_req_if.sink                              req,
	sks_rsp_if.source                            rsp
);
	import sks_pkg::*;

	// The controller sequences each search: it opens the window, alternates
	// table reads with compares and hands the result to the output register.
	sks_cmd_t cmd;
	sks_sts_t sts;

	sks_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// The datapath holds the table memories, the configuration registers,
	// the search window and the result registers.
	sks_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire
